FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle check, off while in reset
`define CMA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle check, also active in reset
`define CMA_CHK_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cma_pkg.sv
`default_nettype none

package cma_pkg;

  localparam int AVG_W  = 24;
  localparam int CFG_W  = 9;
  localparam int FRAC_W = 8;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/cma_if.sv
`default_nettype none

interface cma_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;
  logic                          last;

  modport source (output valid, output sample, output restart, output last, input ready);
  modport sink   (input valid, input sample, input restart, input last, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;
  logic                    filled;
  logic                    last_out;

  modport source (output valid, output average, output filled, output last_out, input ready);
  modport sink   (input valid, input average, input filled, input last_out, output ready);
endinterface

`default_nettype wire

FILE: sv/cma_ram.sv
`default_nettype none

module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/cma_fifo.sv
`default_nettype none

module cma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cma_front.sv
`default_nettype none

module cma_front import cma_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 256,
  parameter int POS_W       = 8,
  parameter int CNT_W       = 9,
  parameter int SUM_W       = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic        [CFG_W-1:0]       cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_restart,
  input  wire logic                          in_last,
  output logic                               q_push,
  input  wire logic                          q_full,
  output logic signed      [SUM_W-1:0]       q_sum,
  output logic             [CNT_W-1:0]       q_cnt,
  output logic                               q_filled,
  output logic                               q_last
);

  front_state_t                   st_r, st_nxt;
  logic        [CNT_W-1:0]        win_r, win_nxt;
  logic        [POS_W-1:0]        pos_r, pos_nxt;
  logic        [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0]  samp_r;
  logic                           clr_r;
  logic                           last_r;

  logic        [POS_W-1:0]        base_pos;
  logic        [CNT_W-1:0]        base_cnt;
  logic signed [SUM_W-1:0]        base_sum;
  logic        [SAMPLE_BITS-1:0]  ram_rdata;
  logic signed [SAMPLE_BITS-1:0]  old_s;
  logic signed [SUM_W-1:0]        upd_sum;
  logic        [CNT_W-1:0]        upd_cnt;
  logic        [POS_W-1:0]        upd_pos;
  logic        [POS_W-1:0]        raddr;
  logic                           ram_we;
  logic        [31:0]             cfg_ext;

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW),
    .AW    (POS_W)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base_pos),
    .wdata (samp_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (st_r == FR_IDLE) && !q_full;
  assign raddr    = in_restart ? '0 : pos_r;
  assign cfg_ext  = 32'(cfg_wr_data);

  assign base_pos = clr_r ? '0 : pos_r;
  assign base_cnt = clr_r ? '0 : cnt_r;
  assign base_sum = clr_r ? '0 : sum_r;

  // slot under the write position holds live data only once the ring is full
  assign old_s   = (base_cnt == win_r) ? ram_rdata : '0;
  assign upd_sum = base_sum - SUM_W'(old_s) + SUM_W'(samp_r);
  assign upd_cnt = (base_cnt < win_r) ? base_cnt + 1'b1 : base_cnt;
  assign upd_pos = ((CNT_W'(base_pos) + 1'b1) == win_r) ? '0 : base_pos + 1'b1;

  assign q_sum    = upd_sum;
  assign q_cnt    = upd_cnt;
  assign q_filled = (upd_cnt == win_r);
  assign q_last   = last_r;

  always_comb begin
    st_nxt  = st_r;
    win_nxt = win_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    ram_we  = 1'b0;
    q_push  = 1'b0;
    case (st_r)
      FR_IDLE: begin
        if (in_valid && in_ready) begin
          st_nxt = FR_UPDATE;
        end
      end
      FR_UPDATE: begin
        ram_we  = 1'b1;
        q_push  = 1'b1;
        sum_nxt = upd_sum;
        cnt_nxt = upd_cnt;
        pos_nxt = upd_pos;
        st_nxt  = FR_IDLE;
      end
      default: begin
        st_nxt = FR_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      if (cfg_ext == 32'd0) begin
        win_nxt = CNT_W'(1);
      end else if (cfg_ext > 32'(MAX_WINDOW)) begin
        win_nxt = CNT_W'(MAX_WINDOW);
      end else begin
        win_nxt = CNT_W'(cfg_wr_data);
      end
      pos_nxt = '0;
      cnt_nxt = '0;
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= FR_IDLE;
      win_r <= CNT_W'(1);
      pos_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      st_r  <= st_nxt;
      win_r <= win_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp_r <= in_sample;
      clr_r  <= in_restart;
      last_r <= in_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cma_back.sv
`default_nettype none

module cma_back import cma_pkg::*; #(
  parameter int SUM_W = 25,
  parameter int CNT_W = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  output logic                         q_pop,
  input  wire logic signed [SUM_W-1:0] q_sum,
  input  wire logic        [CNT_W-1:0] q_cnt,
  input  wire logic                    q_filled,
  input  wire logic                    q_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed      [AVG_W-1:0] out_average,
  output logic                         out_filled,
  output logic                         out_last
);

  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int Q_W    = (DIV_W + 1 > AVG_W) ? DIV_W + 1 : AVG_W;
  localparam int STEP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  back_state_t              st_r, st_nxt;
  logic                     ovld_r, ovld_nxt;
  logic        [STEP_W-1:0] step_r, step_nxt;
  logic        [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic        [DIV_W-1:0]  quo_r, quo_nxt;
  logic        [CNT_W-1:0]  rem_r, rem_nxt;
  logic        [CNT_W-1:0]  dsr_r;
  logic                     neg_r;
  logic                     fill_r;
  logic                     last_r;
  logic signed [AVG_W-1:0]  avg_r;
  logic                     ofill_r;
  logic                     olast_r;

  logic        [SUM_W-1:0]  mag;
  logic        [CNT_W:0]    shifted;
  logic        [CNT_W:0]    diff;
  logic                     ge;
  logic signed [DIV_W:0]    qs;
  logic signed [Q_W-1:0]    q_ext;
  logic                     load_out;

  assign mag     = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = (shifted >= {1'b0, dsr_r});
  assign qs      = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign q_ext   = Q_W'(qs);

  assign out_valid   = ovld_r;
  assign out_average = avg_r;
  assign out_filled  = ofill_r;
  assign out_last    = olast_r;

  always_comb begin
    st_nxt   = st_r;
    ovld_nxt = ovld_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    q_pop    = 1'b0;
    load_out = 1'b0;
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          dvd_nxt  = {mag, FRAC_W'(0)};
          quo_nxt  = '0;
          rem_nxt  = '0;
          step_nxt = STEP_W'(DIV_W - 1);
          st_nxt   = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], ge};
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        if (step_r == '0) begin
          st_nxt = BK_HOLD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      BK_HOLD: begin
        if (!ovld_r || out_ready) begin
          load_out = 1'b1;
          ovld_nxt = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    if (q_pop) begin
      dsr_r  <= q_cnt;
      neg_r  <= q_sum[SUM_W-1];
      fill_r <= q_filled;
      last_r <= q_last;
    end
    if (load_out) begin
      avg_r   <= q_ext[AVG_W-1:0];
      ofill_r <= fill_r;
      olast_r <= last_r;
    end
  end

endmodule

`default_nettype wire

FILE: sv/causal_moving_average_core.sv
// Channel  | Dir | Payload                            | Handshake
// in_if    | in  | sample, restart, last              | valid/ready
// out_if   | out | average (Q.8), filled, last_out    | valid/ready
// cfg      | in  | window length                      | cfg_wr_en, no wait
//
// Front: history RAM read, then sum update and RAM write; a new sample is taken only after the update.
// Back: each item is popped, run through the one-bit-per-cycle restoring divider
//   and held for the output; a new item is popped only once the back is idle again.
// A 2-entry queue sits between front and back, so each side stalls alone.
// Synchronous active-low reset; no RAM clearing pass, the fill count masks
//   history slots not yet written since the last clear.
`default_nettype none

module causal_moving_average_core import cma_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  cma_in_if.sink                in_if,
  cma_out_if.source             out_if
);

  localparam int POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int Q_WIDTH = SUM_W + CNT_W + 2;
  localparam int Q_DEPTH = 2;

  logic                    push, full, pop, empty;
  logic signed [SUM_W-1:0] f_sum;
  logic        [CNT_W-1:0] f_cnt;
  logic                    f_filled, f_last;
  logic        [Q_WIDTH-1:0] q_din, q_dout;

  cma_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW),
    .POS_W       (POS_W),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_sample   (in_if.sample),
    .in_restart  (in_if.restart),
    .in_last     (in_if.last),
    .q_push      (push),
    .q_full      (full),
    .q_sum       (f_sum),
    .q_cnt       (f_cnt),
    .q_filled    (f_filled),
    .q_last      (f_last)
  );

  assign q_din = {f_sum, f_cnt, f_filled, f_last};

  cma_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .full  (full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (empty)
  );

  cma_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (empty),
    .q_pop       (pop),
    .q_sum       (q_dout[Q_WIDTH-1 -: SUM_W]),
    .q_cnt       (q_dout[CNT_W+1:2]),
    .q_filled    (q_dout[1]),
    .q_last      (q_dout[0]),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_average (out_if.average),
    .out_filled  (out_if.filled),
    .out_last    (out_if.last_out)
  );

endmodule

`default_nettype wire

FILE: sv/cma_checker.sv
`default_nettype none

`include "assert_macros.svh"

module cma_checker import cma_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [AVG_W-1:0] out_average,
  input wire logic             out_filled,
  input wire logic             out_last
);

  // stalled result holds
  `CMA_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_average) && $stable(out_filled) && $stable(out_last), "result changed while stalled")

  // front takes no new input while it updates after a transfer
  `CMA_CHK_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

  `CMA_CHK_RST(a_rst_out, !rst_n, !out_valid, "result valid after reset")

endmodule

bind causal_moving_average_core cma_checker u_cma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_average (out_if.average),
  .out_filled  (out_if.filled),
  .out_last    (out_if.last_out)
);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import cma_pkg::*;

  localparam int RING_DEPTH  = 256;
  localparam int SETTLE_CYC  = 80;
  localparam int RUN_LIMIT_NS = 50_000_000;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    filled;
    logic                    last_out;
  } avg_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  cma_in_if #(.SAMPLE_BITS(16)) in_ch ();
  cma_out_if out_ch ();

  causal_moving_average_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // boxcar state
  logic signed [15:0] ring [RING_DEPTH];
  int                 ring_sum;
  int unsigned        ring_pos;
  int unsigned        seen;
  logic [CFG_W-1:0]   win_reg;

  avg_result_t pending_avgs[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          gap_before = 0;
  bit          in_held = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
    ring_sum = 0;
    ring_pos = 0;
    seen     = 0;
  endfunction

  function automatic void load_window(input logic [CFG_W-1:0] value);
    win_reg = value;
    clear_ring();
  endfunction

  function automatic void predict_average(input logic signed [15:0] s, input logic rs,
                                          input logic lst);
    int unsigned eff;
    longint      quot;
    avg_result_t res;
    eff = (win_reg == 0) ? 1 : ((win_reg > RING_DEPTH) ? RING_DEPTH : win_reg);
    if (rs) clear_ring();
    if (ring_pos >= eff) ring_pos = 0;
    ring_sum = ring_sum - ring[ring_pos];
    ring[ring_pos] = s;
    ring_sum = ring_sum + s;
    ring_pos++;
    if (ring_pos >= eff) ring_pos = 0;
    if (seen < eff) seen++;
    quot = (longint'(ring_sum) * 256) / longint'(seen);
    res.average  = quot[AVG_W-1:0];
    res.filled   = (seen >= eff);
    res.last_out = lst;
    pending_avgs.push_back(res);
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic rs = 1'b0,
                             input logic lst = 1'b0);
    if (gap_before > 0) repeat (gap_before) @(posedge clk);
    in_ch.sample  <= s;
    in_ch.restart <= rs;
    in_ch.last    <= lst;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_average(s, rs, lst);
    gap_before = pick_gap();
    if (gap_before > 0) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end else begin
      in_held = 1'b1;
    end
  endtask

  task automatic drain_results();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
      gap_before = 1;
    end
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    load_window(value);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: ready with random stalls
  initial begin : ready_gen
    int stall_len;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    avg_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_avgs.size() == 0) begin
        $error("unexpected transfer: average %0d filled %0b last_out %0b",
               out_ch.average, out_ch.filled, out_ch.last_out);
        mismatches++;
      end else begin
        want = pending_avgs.pop_front();
        if (out_ch.average !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, out_ch.average);
          mismatches++;
        end
        if (out_ch.filled !== want.filled) begin
          $error("filled: expected %0b, actual %0b", want.filled, out_ch.filled);
          mismatches++;
        end
        if (out_ch.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_ch.last_out);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_window();
    send_sample(16'sd32767);
    send_sample(-16'sd32768, 1'b0, 1'b1);
    send_sample(16'sd0);
    send_sample(-16'sd1, 1'b0, 1'b1);
  endtask

  task automatic test_truncation();
    write_window(9'd3);
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd2, 1'b0, 1'b1);
  endtask

  task automatic test_zero_window();
    write_window(9'd0);
    send_sample(16'sd100);
    send_sample(-16'sd7);
  endtask

  task automatic test_oversized_window();
    write_window(9'd511);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    write_window(9'd257);
    send_sample(16'sd32767);
    send_sample(16'sd5);
  endtask

  task automatic test_restart();
    write_window(9'd4);
    send_sample(16'sd10, 1'b1);
    send_sample(16'sd20);
    send_sample(16'sd30, 1'b1);
    send_sample(16'sd40, 1'b0, 1'b1);
  endtask

  task automatic test_write_clears();
    send_sample(16'sd5, 1'b0, 1'b1);
    write_window(9'd4);
    send_sample(16'sd6);
    write_window(9'd256);
    send_sample(-16'sd32768);
  endtask

  task automatic test_random_stream();
    logic [CFG_W-1:0]   windows[12];
    logic signed [15:0] s;
    int                 count;
    int                 mode;
    int                 r;
    windows = '{9'd1, 9'd2, 9'd5, 9'd16, 9'd256, 9'd0, 9'd300,
                9'd511, 9'd3, 9'd128, 9'd257, 9'd0};
    windows[11] = 9'($urandom_range(0, 511));
    for (int p = 0; p < 12; p++) begin
      write_window(windows[p]);
      calm  = (p % 4 == 1);
      count = (windows[p] >= 128) ? 280 : 110;
      mode  = $urandom_range(0, 3);
      for (int k = 0; k < count; k++) begin
        r = $urandom_range(0, 99);
        if (mode == 1 && r < 85) s = 16'sd32767;
        else if (mode == 2 && r < 85) s = -16'sd32768;
        else if (r < 10) s = 16'sd32767;
        else if (r < 20) s = -16'sd32768;
        else if (r < 30) s = 16'($urandom_range(0, 8) - 4);
        else s = 16'($urandom);
        send_sample(s, ($urandom_range(0, 49) == 0), 1'($urandom_range(0, 1)));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;
    in_ch.last    = 1'b0;
    load_window(9'd1);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_truncation();
    test_zero_window();
    test_oversized_window();
    test_restart();
    test_write_clears();
    test_random_stream();

    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
